### hdl/qacc_pkg.sv
// Shared types and constants for the quadrature accumulator.
`default_nettype none

package qacc_pkg;

  localparam int SAMPLE_W = 32;
  localparam int STEP_W = 25;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 25'd8388608;

  // rule modes
  localparam logic [MODE_W-1:0] MODE_MID = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRAP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIMP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ODD = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SAT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FEW = 2'd3;

  // divisor of the closing formula, the code is the divisor itself
  localparam logic [1:0] DIV_ONE = 2'd1;
  localparam logic [1:0] DIV_TWO = 2'd2;
  localparam logic [1:0] DIV_THREE = 2'd3;

  // floor(y/3) = (y * RECIP3) >> RECIP_SHIFT for y below 2^34
  localparam int QUO_IN_W = 34;
  localparam int RECIP_W = 35;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP3 = 35'd22906492246;

  localparam logic signed [SAMPLE_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_NEG = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0] div;
    logic [STATUS_W-1:0] status;
  } fin_ctl_t;

endpackage

`default_nettype wire

### hdl/qacc_accum.sv
// Input register, running weighted sum and closing total per interval.
`default_nettype none

module qacc_accum #(
  parameter int MAX_SAMPLES = 65536,
  parameter int TOT_W = 52
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic item_stall,
  input  wire logic signed [qacc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic last,
  input  wire logic [qacc_pkg::MODE_W-1:0] mode,
  output logic tot_valid,
  input  wire logic tot_ready,
  output logic signed [TOT_W-1:0] tot,
  output qacc_pkg::fin_ctl_t tot_ctl
);

  localparam int CNT_W = $clog2(MAX_SAMPLES);

  logic s0_v;
  logic signed [qacc_pkg::SAMPLE_W-1:0] s0_sample;
  logic s0_last;

  logic signed [TOT_W-1:0] weighted_sum;
  logic signed [qacc_pkg::SAMPLE_W-1:0] first_value;
  logic [CNT_W-1:0] sample_count;

  logic fin;
  logic t_rdy;
  logic s0_go;
  logic signed [TOT_W-1:0] s_ext;
  logic signed [TOT_W-1:0] fv_ext;
  logic signed [TOT_W-1:0] addend;
  logic signed [TOT_W-1:0] tot_next;
  qacc_pkg::fin_ctl_t ctl_next;

  assign fin = s0_last || (sample_count == CNT_W'(MAX_SAMPLES - 1));
  assign t_rdy = !tot_valid || tot_ready;
  assign s0_go = s0_v && (!fin || t_rdy);
  assign item_stall = s0_v && !s0_go;

  assign s_ext = TOT_W'(s0_sample);
  assign fv_ext = (sample_count == '0) ? s_ext : TOT_W'(first_value);

  always_comb begin
    addend = s_ext;
    if (mode != qacc_pkg::MODE_MID) begin
      if (sample_count == '0) begin
        addend = '0;
      end else if (mode == qacc_pkg::MODE_SIMP) begin
        addend = sample_count[0] ? (s_ext <<< 2) : (s_ext <<< 1);
      end
    end
  end

  always_comb begin
    ctl_next.div = qacc_pkg::DIV_ONE;
    ctl_next.status = qacc_pkg::STAT_OK;
    tot_next = weighted_sum + s_ext;
    case (mode)
      qacc_pkg::MODE_TRAP: begin
        ctl_next.div = qacc_pkg::DIV_TWO;
        tot_next = (weighted_sum <<< 1) + fv_ext + s_ext;
        if (sample_count == '0) ctl_next.status = qacc_pkg::STAT_FEW;
      end
      qacc_pkg::MODE_SIMP: begin
        ctl_next.div = qacc_pkg::DIV_THREE;
        tot_next = weighted_sum + fv_ext + s_ext;
        if (sample_count == '0) begin
          ctl_next.status = qacc_pkg::STAT_FEW;
        end else if (sample_count[0]) begin
          ctl_next.status = qacc_pkg::STAT_ODD;
        end
      end
      default: begin
        ctl_next.div = qacc_pkg::DIV_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s0_sample <= sample;
      s0_last <= last;
    end
    if (s0_go && fin && t_rdy) begin
      tot <= tot_next;
      tot_ctl <= ctl_next;
    end
    if (rst) begin
      s0_v <= 1'b0;
      tot_valid <= 1'b0;
      weighted_sum <= '0;
      first_value <= '0;
      sample_count <= '0;
    end else begin
      if (!item_stall) s0_v <= item_valid;
      if (t_rdy) tot_valid <= s0_go && fin;
      if (s0_go) begin
        if (fin) begin
          weighted_sum <= '0;
          first_value <= '0;
          sample_count <= '0;
        end else begin
          weighted_sum <= weighted_sum + addend;
          if (sample_count == '0) first_value <= s0_sample;
          sample_count <= sample_count + 1'b1;
        end
      end
    end
  end

  count_in_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(MAX_SAMPLES - 1))
    else $error("sample count past interval limit");

  state_cleared_after_close: assert property (@(posedge clk) disable iff (rst)
    s0_go && fin |=> sample_count == '0 && weighted_sum == '0)
    else $error("interval state not cleared after closing sample");

endmodule

`default_nettype wire

### hdl/qacc_scale.sv
// Scaling pipeline: |total| * step, rounding, divide by rule, saturation.
`default_nettype none

module qacc_scale #(
  parameter int FRAC_BITS = 24,
  parameter int TOT_W = 52
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [qacc_pkg::STEP_W-1:0] step_size,
  input  wire logic tot_valid,
  output logic tot_ready,
  input  wire logic signed [TOT_W-1:0] tot,
  input  wire qacc_pkg::fin_ctl_t tot_ctl,
  output logic result_valid,
  input  wire logic result_stall,
  output logic signed [qacc_pkg::SAMPLE_W-1:0] integral,
  output logic [qacc_pkg::STATUS_W-1:0] status
);

  localparam int MAG_W = TOT_W;
  localparam int LO_W = MAG_W / 2;
  localparam int HI_W = MAG_W - LO_W;
  localparam int PR_W = MAG_W + qacc_pkg::STEP_W + 1;
  localparam int Y_W = PR_W - FRAC_BITS;
  localparam int QW = qacc_pkg::QUO_IN_W;
  localparam int W = qacc_pkg::SAMPLE_W;

  // stage a: magnitude
  logic a_v, a_neg;
  logic [MAG_W-1:0] a_mag;
  qacc_pkg::fin_ctl_t a_ctl;
  // stage b: partial products and saturation threshold
  logic b_v, b_neg;
  logic [LO_W+qacc_pkg::STEP_W-1:0] b_pl;
  logic [HI_W+qacc_pkg::STEP_W-1:0] b_ph;
  logic [QW-1:0] b_thr;
  qacc_pkg::fin_ctl_t b_ctl;
  // stage c: rounded and shifted product
  logic c_v, c_neg, c_sat;
  logic [Y_W-1:0] c_y;
  qacc_pkg::fin_ctl_t c_ctl;
  // stage d: quotient
  logic d_v, d_neg, d_sat;
  logic [W-1:0] d_q;
  qacc_pkg::fin_ctl_t d_ctl;

  logic o_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
  logic [QW-1:0] thr_base;
  logic [QW-1:0] thr_next;
  logic [PR_W-1:0] prod;
  logic [Y_W-1:0] y_next;
  logic [QW-1:0] yn;
  logic [QW+qacc_pkg::RECIP_W-1:0] prod3;
  logic [W-1:0] q_next;

  assign o_rdy = !result_valid || !result_stall;
  assign d_rdy = !d_v || o_rdy;
  assign c_rdy = !c_v || d_rdy;
  assign b_rdy = !b_v || c_rdy;
  assign a_rdy = !a_v || b_rdy;
  assign tot_ready = a_rdy;

  assign thr_base = QW'(33'h0_8000_0000) + QW'(a_neg);
  always_comb begin
    case (a_ctl.div)
      qacc_pkg::DIV_THREE: thr_next = thr_base + (thr_base << 1);
      qacc_pkg::DIV_TWO: thr_next = thr_base << 1;
      default: thr_next = thr_base;
    endcase
  end

  assign prod = PR_W'({b_ph, {LO_W{1'b0}}}) + PR_W'(b_pl)
              + (PR_W'(b_ctl.div) << (FRAC_BITS - 1));
  assign y_next = prod[PR_W-1:FRAC_BITS];

  assign yn = c_y[QW-1:0];
  assign prod3 = yn * qacc_pkg::RECIP3;
  always_comb begin
    case (c_ctl.div)
      qacc_pkg::DIV_THREE: q_next = prod3[qacc_pkg::RECIP_SHIFT +: W];
      qacc_pkg::DIV_TWO: q_next = yn[W:1];
      default: q_next = yn[W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_rdy && tot_valid) begin
      a_neg <= tot[TOT_W-1];
      a_mag <= tot[TOT_W-1] ? MAG_W'(-tot) : MAG_W'(tot);
      a_ctl <= tot_ctl;
    end
    if (b_rdy && a_v) begin
      b_neg <= a_neg;
      b_pl <= a_mag[LO_W-1:0] * step_size;
      b_ph <= a_mag[MAG_W-1:LO_W] * step_size;
      b_thr <= thr_next;
      b_ctl <= a_ctl;
    end
    if (c_rdy && b_v) begin
      c_neg <= b_neg;
      c_y <= y_next;
      c_sat <= y_next >= Y_W'(b_thr);
      c_ctl <= b_ctl;
    end
    if (d_rdy && c_v) begin
      d_neg <= c_neg;
      d_sat <= c_sat;
      d_q <= q_next;
      d_ctl <= c_ctl;
    end
    if (o_rdy && d_v) begin
      if (d_ctl.status != qacc_pkg::STAT_OK) begin
        integral <= '0;
        status <= d_ctl.status;
      end else if (d_sat) begin
        integral <= d_neg ? qacc_pkg::SAT_NEG : qacc_pkg::SAT_POS;
        status <= qacc_pkg::STAT_SAT;
      end else begin
        integral <= d_neg ? -$signed(d_q) : $signed(d_q);
        status <= qacc_pkg::STAT_OK;
      end
    end
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_rdy) a_v <= tot_valid;
      if (b_rdy) b_v <= a_v;
      if (c_rdy) c_v <= b_v;
      if (d_rdy) d_v <= c_v;
      if (o_rdy) result_valid <= d_v;
    end
  end

  sat_gives_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == qacc_pkg::STAT_SAT
      |-> integral == qacc_pkg::SAT_POS || integral == qacc_pkg::SAT_NEG)
    else $error("saturated result not at a limit");

  bad_count_gives_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == qacc_pkg::STAT_ODD || status == qacc_pkg::STAT_FEW)
      |-> integral == '0)
    else $error("error status with nonzero integral");

  quotient_fits: assert property (@(posedge clk) disable iff (rst)
    d_v && !d_sat |-> d_q <= 32'h8000_0000)
    else $error("unsaturated quotient out of range");

endmodule

`default_nettype wire

### hdl/quadrature_accumulator.sv
// Top level: streaming midpoint, trapezoid and Simpson integration.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  item     | item_valid / item_stall    | sample (s Q8.24), last
//  result   | result_valid / result_stall| integral (s Q8.24), status
//  config   | cfg_write                  | cfg_index, cfg_data
//
// One sample is taken per cycle while item_stall is low; the running sum is a
// single add per beat. A closing sample's result passes through the total
// register behind the input register and then five scaling stages.
// Result stalls fill the scaling stages first; item_stall rises only when a
// closing beat cannot enter them. Synchronous reset clears all valid flags
// and the interval state; rule_mode resets to midpoint, step_size to 0.5.
`default_nettype none

module quadrature_accumulator #(
  parameter int MAX_SAMPLES = 65536,
  parameter int FRAC_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [qacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qacc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic item_valid,
  output logic item_stall,
  input  wire logic signed [qacc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic last,
  output logic result_valid,
  input  wire logic result_stall,
  output logic signed [qacc_pkg::SAMPLE_W-1:0] integral,
  output logic [qacc_pkg::STATUS_W-1:0] status
);

  localparam int TOT_W = qacc_pkg::SAMPLE_W + $clog2(MAX_SAMPLES) + 4;

  logic [qacc_pkg::MODE_W-1:0] rule_mode;
  logic [qacc_pkg::STEP_W-1:0] step_size;
  logic [qacc_pkg::MODE_W-1:0] mode;

  logic tot_valid;
  logic tot_ready;
  logic signed [TOT_W-1:0] tot;
  qacc_pkg::fin_ctl_t tot_ctl;

  assign mode = (rule_mode == qacc_pkg::MODE_SPARE) ? qacc_pkg::MODE_MID : rule_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode <= qacc_pkg::MODE_MID;
      step_size <= qacc_pkg::STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        qacc_pkg::REG_RULE_MODE: rule_mode <= cfg_data[qacc_pkg::MODE_W-1:0];
        qacc_pkg::REG_STEP_SIZE: step_size <= cfg_data[qacc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  qacc_accum #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .TOT_W(TOT_W)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .sample(sample),
    .last(last),
    .mode(mode),
    .tot_valid(tot_valid),
    .tot_ready(tot_ready),
    .tot(tot),
    .tot_ctl(tot_ctl)
  );

  qacc_scale #(
    .FRAC_BITS(FRAC_BITS),
    .TOT_W(TOT_W)
  ) u_scale (
    .clk(clk),
    .rst(rst),
    .step_size(step_size),
    .tot_valid(tot_valid),
    .tot_ready(tot_ready),
    .tot(tot),
    .tot_ctl(tot_ctl),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .integral(integral),
    .status(status)
  );

endmodule

`default_nettype wire

### verif/tb_quadrature_accumulator.sv
// Testbench for quadrature_accumulator: directed table, back-pressure, random.
`timescale 1ns / 100ps

module tb_quadrature_accumulator;

  localparam int FRAC = 24;
  localparam int MAX_SAMPLES = 65536;
  localparam int SETTLE = 12;
  localparam int TAIL = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 530;
  localparam logic [qacc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [qacc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [qacc_pkg::STEP_W-1:0] STEP_ONE = 25'd16777216;
  localparam logic [qacc_pkg::STEP_W-1:0] STEP_ZERO = 25'd0;

  typedef struct packed {
    logic signed [qacc_pkg::SAMPLE_W-1:0] value;
    logic [qacc_pkg::STATUS_W-1:0] code;
  } integral_rec_t;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [qacc_pkg::CFG_IDX_W-1:0] idx;
    logic [qacc_pkg::CFG_DATA_W-1:0] data;
    logic signed [qacc_pkg::SAMPLE_W-1:0] smp;
    logic lst;
    logic known;
    logic signed [qacc_pkg::SAMPLE_W-1:0] want_value;
    logic [qacc_pkg::STATUS_W-1:0] want_code;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [qacc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qacc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic signed [qacc_pkg::SAMPLE_W-1:0] sample;
  logic last;
  logic result_valid;
  logic result_stall;
  logic signed [qacc_pkg::SAMPLE_W-1:0] integral;
  logic [qacc_pkg::STATUS_W-1:0] status;

  // integrator state as the block should hold it
  logic [qacc_pkg::MODE_W-1:0] acc_mode;
  logic [qacc_pkg::STEP_W-1:0] acc_step;
  longint acc_sum;
  longint acc_first;
  int acc_count;

  integral_rec_t integrals_due[$];
  stim_row_t stimulus_rows[$];

  logic fix_on;
  logic signed [qacc_pkg::SAMPLE_W-1:0] fix_value;
  logic [qacc_pkg::STATUS_W-1:0] fix_code;
  bit tx_idle;
  bit rx_idle;
  int hold_len;
  int errors;
  int n_samples;
  int n_integrals;
  int n_settings;
  int quiet;

  quadrature_accumulator i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .sample(sample),
    .last(last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .integral(integral),
    .status(status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  // takes one sample into the integrator; queues an integral when the interval closes
  task automatic absorb_sample(input logic signed [qacc_pkg::SAMPLE_W-1:0] s,
                               input logic fin_mark);
    logic [qacc_pkg::MODE_W-1:0] rule;
    int idx;
    longint sv;
    longint total;
    logic [1:0] div;
    logic [qacc_pkg::STATUS_W-1:0] code;
    logic signed [qacc_pkg::SAMPLE_W-1:0] value;
    logic [63:0] mag;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] lim;
    bit neg;
    integral_rec_t rec;
    rule = (acc_mode == qacc_pkg::MODE_SPARE) ? qacc_pkg::MODE_MID : acc_mode;
    idx = acc_count;
    sv = s;
    if (idx == 0) acc_first = sv;
    if (!fin_mark && idx < MAX_SAMPLES - 1) begin
      if (rule == qacc_pkg::MODE_MID) begin
        acc_sum += sv;
      end else if (idx != 0) begin
        acc_sum += (rule == qacc_pkg::MODE_SIMP) ? sv * (idx[0] ? 4 : 2) : sv;
      end
      acc_count = idx + 1;
    end else begin
      code = qacc_pkg::STAT_OK;
      value = '0;
      case (rule)
        qacc_pkg::MODE_TRAP: begin
          if (idx == 0) code = qacc_pkg::STAT_FEW;
          total = 2 * acc_sum + acc_first + sv;
          div = qacc_pkg::DIV_TWO;
        end
        qacc_pkg::MODE_SIMP: begin
          if (idx == 0) code = qacc_pkg::STAT_FEW;
          else if (idx[0]) code = qacc_pkg::STAT_ODD;
          total = acc_sum + acc_first + sv;
          div = qacc_pkg::DIV_THREE;
        end
        default: begin
          total = acc_sum + sv;
          div = qacc_pkg::DIV_ONE;
        end
      endcase
      if (code == qacc_pkg::STAT_OK) begin
        neg = total < 0;
        mag = neg ? -total : total;
        num = 128'(mag) * 128'(acc_step) + (128'(div) << (FRAC - 1));
        quo = num / (128'(div) << FRAC);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
          value = neg ? qacc_pkg::SAT_NEG : qacc_pkg::SAT_POS;
          code = qacc_pkg::STAT_SAT;
        end else begin
          value = neg ? -quo[31:0] : quo[31:0];
        end
      end
      rec.value = fix_on ? fix_value : value;
      rec.code = fix_on ? fix_code : code;
      integrals_due.push_back(rec);
      acc_sum = 0;
      acc_first = 0;
      acc_count = 0;
    end
  endtask

  // called at a falling edge
  task automatic send_item(input logic signed [qacc_pkg::SAMPLE_W-1:0] s, input logic l,
                           input logic known,
                           input logic signed [qacc_pkg::SAMPLE_W-1:0] kval,
                           input logic [qacc_pkg::STATUS_W-1:0] kcode);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample = s;
    last = l;
    fix_on = known;
    fix_value = kval;
    fix_code = kcode;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_valid = 1'b0;
    while (integrals_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [qacc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qacc_pkg::CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx == qacc_pkg::REG_RULE_MODE) acc_mode = data[qacc_pkg::MODE_W-1:0];
    else if (idx == qacc_pkg::REG_STEP_SIZE) acc_step = data[qacc_pkg::STEP_W-1:0];
    n_settings++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic stim_row_t write_row(input logic [qacc_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [qacc_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t beat_row(input logic signed [qacc_pkg::SAMPLE_W-1:0] s,
                                         input logic l);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.smp = s;
    r.lst = l;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic signed [qacc_pkg::SAMPLE_W-1:0] s,
                                          input logic signed [qacc_pkg::SAMPLE_W-1:0] val,
                                          input logic [qacc_pkg::STATUS_W-1:0] code);
    stim_row_t r;
    r = beat_row(s, 1'b1);
    r.known = 1'b1;
    r.want_value = val;
    r.want_code = code;
    return r;
  endfunction

  function automatic logic signed [qacc_pkg::SAMPLE_W-1:0] draw_sample();
    logic signed [qacc_pkg::SAMPLE_W-1:0] s;
    case ($urandom_range(0, 7))
      0: s = $urandom_range(0, 1) ? qacc_pkg::SAT_POS : qacc_pkg::SAT_NEG;
      1: s = '0;
      2: s = '1;
      3, 4: s = $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // interval length, mostly short; Simpson mostly gets an even interval count
  function automatic int draw_span(input logic [qacc_pkg::MODE_W-1:0] rule);
    int n;
    case ($urandom_range(0, 19))
      0: n = $urandom_range(31, 100);
      1, 2, 3, 4, 5: n = $urandom_range(9, 30);
      default: n = $urandom_range(1, 8);
    endcase
    if (rule == qacc_pkg::MODE_SIMP && $urandom_range(0, 3) != 0 && !n[0]) n++;
    return n;
  endfunction

  // scoreboard
  always @(posedge clk) begin : monitor
    integral_rec_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (integrals_due.size() == 0) begin
          flag_mismatch($sformatf("integral %h status %0d with nothing due", integral, status));
        end else begin
          want = integrals_due.pop_front();
          if (integral !== want.value)
            flag_mismatch($sformatf("integral %h, want %h", integral, want.value));
          if (status !== want.code)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.code));
          n_integrals++;
        end
      end
      if (item_valid && !item_stall) begin
        absorb_sample(sample, last);
        n_samples++;
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d integrals outstanding",
               quiet, integrals_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall per beat, long hold-off on request
  initial begin : receiver
    int n;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if (n > 0) begin
        result_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid && hold_len == 0);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int span;
    int done;
    int phase_items;
    int n_random;
    logic [qacc_pkg::STEP_W-1:0] step;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    sample = '0;
    last = 1'b0;
    fix_on = 1'b0;
    fix_value = '0;
    fix_code = qacc_pkg::STAT_OK;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_len = 0;
    errors = 0;
    n_samples = 0;
    n_integrals = 0;
    n_settings = 0;
    n_random = 0;
    quiet = 0;
    acc_mode = qacc_pkg::MODE_MID;
    acc_step = qacc_pkg::STEP_RESET;
    acc_sum = 0;
    acc_first = 0;
    acc_count = 0;

    stimulus_rows.push_back(known_row(32'sh0100_0000, 32'sh0080_0000, qacc_pkg::STAT_OK));
    stimulus_rows.push_back(write_row(qacc_pkg::REG_STEP_SIZE, STEP_ONE));
    stimulus_rows.push_back(beat_row(32'sh7FFF_FFFF, 1'b0));
    stimulus_rows.push_back(known_row(32'sh0000_0001, qacc_pkg::SAT_POS, qacc_pkg::STAT_SAT));
    stimulus_rows.push_back(beat_row(32'sh8000_0000, 1'b0));
    stimulus_rows.push_back(known_row(32'shFFFF_FFFF, qacc_pkg::SAT_NEG, qacc_pkg::STAT_SAT));
    stimulus_rows.push_back(beat_row(32'sh8000_0000, 1'b1));
    stimulus_rows.push_back(write_row(qacc_pkg::REG_RULE_MODE, 25'(qacc_pkg::MODE_TRAP)));
    stimulus_rows.push_back(known_row(32'sh1234_5678, '0, qacc_pkg::STAT_FEW));
    stimulus_rows.push_back(beat_row(32'sh0100_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh0200_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh0300_0000, 1'b1));
    stimulus_rows.push_back(write_row(qacc_pkg::REG_RULE_MODE, 25'(qacc_pkg::MODE_SIMP)));
    stimulus_rows.push_back(write_row(qacc_pkg::REG_STEP_SIZE, STEP_ZERO));
    stimulus_rows.push_back(beat_row(32'sh0100_0000, 1'b0));
    stimulus_rows.push_back(known_row(32'sh0100_0000, '0, qacc_pkg::STAT_ODD));
    stimulus_rows.push_back(known_row(32'sh7FFF_FFFF, '0, qacc_pkg::STAT_FEW));
    stimulus_rows.push_back(beat_row(32'sh7FFF_FFFF, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh8000_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh7FFF_FFFF, 1'b1));
    stimulus_rows.push_back(write_row(qacc_pkg::REG_STEP_SIZE, STEP_ONE));
    stimulus_rows.push_back(beat_row(32'shFFFF_FFFF, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh8000_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh7FFF_FFFF, 1'b1));
    // spare mode code behaves as midpoint; upper data bits are dropped
    stimulus_rows.push_back(write_row(qacc_pkg::REG_RULE_MODE,
                                      25'h1FF_FFFC | 25'(qacc_pkg::MODE_SPARE)));
    stimulus_rows.push_back(beat_row(32'sh1234_5678, 1'b1));
    stimulus_rows.push_back(write_row(REG_SPARE_A, 25'h1FF_FFFF));
    stimulus_rows.push_back(write_row(REG_SPARE_B, 25'h000_0000));
    // rule switched inside an interval
    stimulus_rows.push_back(write_row(qacc_pkg::REG_RULE_MODE, 25'(qacc_pkg::MODE_TRAP)));
    stimulus_rows.push_back(beat_row(32'sh0040_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'shFF80_0000, 1'b0));
    stimulus_rows.push_back(write_row(qacc_pkg::REG_RULE_MODE, 25'(qacc_pkg::MODE_SIMP)));
    stimulus_rows.push_back(beat_row(32'sh0100_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh00C0_0000, 1'b0));
    stimulus_rows.push_back(beat_row(32'sh0010_0000, 1'b1));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stimulus_rows[i]) begin
      r = stimulus_rows[i];
      if (r.kind == ROW_WRITE) begin
        drain_results();
        write_reg(r.idx, r.data);
      end else begin
        send_item(r.smp, r.lst, r.known, r.want_value, r.want_code);
      end
    end

    // back-pressure: receiver holds off while closing beats keep coming
    drain_results();
    write_reg(qacc_pkg::REG_RULE_MODE, 25'(qacc_pkg::MODE_MID));
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_len = 80;
    for (int j = 0; j < 40; j++) send_item(draw_sample(), 1'b1, 1'b0, '0, qacc_pkg::STAT_OK);
    drain_results();

    while (n_random < RANDOM_ITEMS) begin
      drain_results();
      write_reg(qacc_pkg::REG_RULE_MODE, 25'($urandom));
      case ($urandom_range(0, 5))
        0: step = STEP_ZERO;
        1: step = STEP_ONE;
        2: step = 25'($urandom_range(1, 4096));
        default: step = 25'($urandom_range(0, STEP_ONE));
      endcase
      write_reg(qacc_pkg::REG_STEP_SIZE, step);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      phase_items = $urandom_range(30, 70);
      done = 0;
      while (done < phase_items) begin
        span = draw_span(acc_mode);
        for (int j = 0; j < span; j++) begin
          if (j > 0 && $urandom_range(0, 39) == 0) begin
            drain_results();
            write_reg(qacc_pkg::REG_RULE_MODE, 25'($urandom_range(0, 3)));
          end
          send_item(draw_sample(), j == span - 1, 1'b0, '0, qacc_pkg::STAT_OK);
          done++;
          n_random++;
        end
      end
    end

    item_valid = 1'b0;
    while (integrals_due.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    $display("Covered %0d samples and %0d integrals over %0d register writes,", n_samples,
             n_integrals, n_settings);
    $display("including a long result hold-off and %0d random samples.", n_random);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
